FILE: rtl/ray_obb_intersect_unit_assert.svh
// ----------------------------------------------------------------------------
// Ray/OBB intersect unit - assertion macros
// Shared forms for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef RAY_OBB_INTERSECT_UNIT_ASSERT_SVH
`define RAY_OBB_INTERSECT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet in reset.
`define ROI_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("roi: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, quiet in reset.
`define ROI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("roi: next-cycle check failed");

`endif

FILE: rtl/roi_pkg.sv
// ----------------------------------------------------------------------------
// Ray/OBB intersect package
// Widths, codes, reset values and word types shared by the unit.
// ----------------------------------------------------------------------------
package roi_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int ZERO_TOLERANCE = 1;
  localparam int NUM_AXES       = 3;

  localparam int AXES    = 3;
  localparam int FACES   = 2 * AXES;
  localparam int COMP_W  = 16;
  localparam int REG_W   = 48;
  localparam int IDX_W   = 3;
  localparam int PT_W    = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;

  localparam int OFF_W   = COMP_W + 1;
  localparam int PF_W    = 2 * COMP_W;
  localparam int PE_W    = COMP_W + OFF_W;
  localparam int F_W     = PF_W + 2;
  localparam int E_W     = PE_W + 2;
  localparam int HS_SH   = 14;
  localparam int S_W     = COMP_W + HS_SH;
  localparam int NS_W    = E_W + 1;
  localparam int FMAG_W  = F_W;
  localparam int NMAG_W  = NS_W;
  localparam int T_SH    = 22;
  localparam int N_W     = NMAG_W + T_SH;
  localparam int TOL_F   = ZERO_TOLERANCE * 16384;
  localparam int FMIN_LOG = (ZERO_TOLERANCE == 0) ? 0 : $clog2(TOL_F + 1) - 1;
  localparam int QB      = N_W - FMIN_LOG;
  localparam int T_W     = QB + 2;
  localparam int TS_W    = 32;
  localparam int DT_W    = COMP_W + TS_W;
  localparam int PS_W    = DT_W - T_SH + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic signed [T_W-1:0]  T_UNB    = T_W'((64'd1 << (QB + 1)) - 64'd1);
  localparam logic signed [T_W-1:0]  T_NUNB   = -T_UNB;
  localparam logic signed [T_W-1:0]  T_SMAX   = T_W'(2147483647);
  localparam logic signed [T_W-1:0]  T_SMIN   = -T_SMAX - T_W'(1);
  localparam logic signed [T_W-1:0]  T_TOL    = T_W'(ZERO_TOLERANCE);
  localparam logic signed [PS_W-1:0] P_MAX    = PS_W'((64'd1 << (PT_W - 1)) - 64'd1);
  localparam logic signed [PS_W-1:0] P_MIN    = -P_MAX - PS_W'(1);
  localparam logic [TS_W-1:0]        MISS_T   = 32'hFFFF_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_AXIS1  = 3'd1,
    REG_AXIS2  = 3'd2,
    REG_AXIS3  = 3'd3,
    REG_HALF   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    FACE_POS1 = 3'd0,
    FACE_NEG1 = 3'd1,
    FACE_POS2 = 3'd2,
    FACE_NEG2 = 3'd3,
    FACE_POS3 = 3'd4,
    FACE_NEG3 = 3'd5,
    FACE_NONE = 3'd6
  } face_e;

  localparam face_e FACE_LUT [FACES] = '{FACE_POS1, FACE_NEG1, FACE_POS2,
                                         FACE_NEG2, FACE_POS3, FACE_NEG3};

  localparam logic [REG_W-1:0] RST_CENTER = 48'd0;
  localparam logic [REG_W-1:0] RST_AXIS1  = 48'd16384;
  localparam logic [REG_W-1:0] RST_AXIS2  = 48'd1073741824;
  localparam logic [REG_W-1:0] RST_AXIS3  = 48'd70368744177664;
  localparam logic [REG_W-1:0] RST_HALF   = 48'd0;

  typedef struct packed {
    logic [REG_W-1:0]            center;
    logic [AXES-1:0][REG_W-1:0]  axis;
    logic [REG_W-1:0]            half;
  } cfg_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] origin_x;
    logic signed [COMP_W-1:0] origin_y;
    logic signed [COMP_W-1:0] origin_z;
    logic signed [COMP_W-1:0] dir_x;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                     hit;
    logic signed [TS_W-1:0]   t_hit;
    logic signed [COMP_W-1:0] point_x;
    logic signed [COMP_W-1:0] point_y;
    logic signed [COMP_W-1:0] point_z;
    logic [2:0]               face;
  } result_t;

  // One classified ray as it waits between front and back.
  typedef struct packed {
    ray_t                        ray;
    logic [AXES-1:0]             par;
    logic [AXES-1:0]             pmiss;
    logic [AXES-1:0]             neg_a;
    logic [AXES-1:0]             neg_b;
    logic [AXES-1:0][FMAG_W-1:0] fmag;
    logic [AXES-1:0][NMAG_W-1:0] na;
    logic [AXES-1:0][NMAG_W-1:0] nb;
  } slab_item_t;

  // What rides alongside the divider stages.
  typedef struct packed {
    ray_t            ray;
    logic [AXES-1:0] par;
    logic [AXES-1:0] pmiss;
    logic [AXES-1:0] neg_a;
    logic [AXES-1:0] neg_b;
  } side_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic signed [COMP_W-1:0] comp(input logic [REG_W-1:0] r,
                                                     input int k);
    return r[k*COMP_W +: COMP_W];
  endfunction

endpackage

FILE: rtl/roi_front.sv
// ----------------------------------------------------------------------------
// Ray/OBB front end
// Projects each ray onto the box axes and classifies every slab.
// ----------------------------------------------------------------------------
module roi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  roi_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  input  roi_pkg::ray_t       ray_i,
  output logic                push_o,
  output roi_pkg::slab_item_t item_o
);

  logic v1_q, v2_q, v3_q;
  roi_pkg::ray_t ray1_q, ray2_q, ray3_q;
  logic signed [roi_pkg::OFF_W-1:0] off_d [roi_pkg::AXES];
  logic signed [roi_pkg::OFF_W-1:0] off1_q [roi_pkg::AXES];
  logic signed [roi_pkg::COMP_W-1:0] dir1 [roi_pkg::AXES];
  logic signed [roi_pkg::COMP_W-1:0] org_i [roi_pkg::AXES];
  logic signed [roi_pkg::PF_W-1:0] pf_d [roi_pkg::AXES][roi_pkg::AXES];
  logic signed [roi_pkg::PE_W-1:0] pe_d [roi_pkg::AXES][roi_pkg::AXES];
  logic signed [roi_pkg::PF_W-1:0] pf2_q [roi_pkg::AXES][roi_pkg::AXES];
  logic signed [roi_pkg::PE_W-1:0] pe2_q [roi_pkg::AXES][roi_pkg::AXES];
  logic signed [roi_pkg::F_W-1:0] f_d [roi_pkg::AXES];
  logic signed [roi_pkg::E_W-1:0] e_d [roi_pkg::AXES];
  logic signed [roi_pkg::F_W-1:0] f3_q [roi_pkg::AXES];
  logic signed [roi_pkg::E_W-1:0] e3_q [roi_pkg::AXES];

  always_comb begin
    org_i[0] = ray_i.origin_x;
    org_i[1] = ray_i.origin_y;
    org_i[2] = ray_i.origin_z;
    dir1[0]  = ray1_q.dir_x;
    dir1[1]  = ray1_q.dir_y;
    dir1[2]  = ray1_q.dir_z;
    for (int k = 0; k < roi_pkg::AXES; k++) begin
      off_d[k] = roi_pkg::OFF_W'(roi_pkg::comp(cfg_i.center, k))
               - roi_pkg::OFF_W'(org_i[k]);
    end
    for (int i = 0; i < roi_pkg::AXES; i++) begin
      for (int k = 0; k < roi_pkg::AXES; k++) begin
        pf_d[i][k] = roi_pkg::comp(cfg_i.axis[i], k) * dir1[k];
        pe_d[i][k] = roi_pkg::comp(cfg_i.axis[i], k) * off1_q[k];
      end
    end
    for (int i = 0; i < roi_pkg::AXES; i++) begin
      f_d[i] = roi_pkg::F_W'(pf2_q[i][0]) + roi_pkg::F_W'(pf2_q[i][1])
             + roi_pkg::F_W'(pf2_q[i][2]);
      e_d[i] = roi_pkg::E_W'(pe2_q[i][0]) + roi_pkg::E_W'(pe2_q[i][1])
             + roi_pkg::E_W'(pe2_q[i][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ray1_q <= ray_i;
    off1_q <= off_d;
    ray2_q <= ray1_q;
    pf2_q  <= pf_d;
    pe2_q  <= pe_d;
    ray3_q <= ray2_q;
    f3_q   <= f_d;
    e3_q   <= e_d;
  end

  // Classify each slab: parallel, parallel and outside, or divide out.
  always_comb begin
    logic signed [roi_pkg::F_W-1:0]  fabs;
    logic signed [roi_pkg::NS_W-1:0] ex, sx, na, nb;
    logic                            par;
    item_o.ray = ray3_q;
    for (int i = 0; i < roi_pkg::AXES; i++) begin
      fabs = f3_q[i][roi_pkg::F_W-1] ? -f3_q[i] : f3_q[i];
      ex   = roi_pkg::NS_W'(e3_q[i]);
      sx   = $signed({{(roi_pkg::NS_W-roi_pkg::S_W){1'b0}},
                      cfg_i.half[i*roi_pkg::COMP_W +: roi_pkg::COMP_W],
                      {roi_pkg::HS_SH{1'b0}}});
      na   = ex + sx;
      nb   = ex - sx;
      par  = (roi_pkg::FMAG_W'(fabs) <= roi_pkg::FMAG_W'(roi_pkg::TOL_F));
      if (i < roi_pkg::NUM_AXES) begin
        item_o.par[i]   = par;
        item_o.pmiss[i] = par && ((ex > sx) || (ex < -sx));
      end else begin
        item_o.par[i]   = 1'b1;
        item_o.pmiss[i] = 1'b0;
      end
      item_o.fmag[i]  = roi_pkg::FMAG_W'(fabs);
      item_o.neg_a[i] = na[roi_pkg::NS_W-1] ^ f3_q[i][roi_pkg::F_W-1];
      item_o.neg_b[i] = nb[roi_pkg::NS_W-1] ^ f3_q[i][roi_pkg::F_W-1];
      item_o.na[i]    = roi_pkg::NMAG_W'(na[roi_pkg::NS_W-1] ? -na : na);
      item_o.nb[i]    = roi_pkg::NMAG_W'(nb[roi_pkg::NS_W-1] ? -nb : nb);
    end
  end

  assign push_o = v3_q;

endmodule

FILE: rtl/roi_queue.sv
// ----------------------------------------------------------------------------
// Ray/OBB slab queue
// Short flop FIFO between the front end and the divider back end.
// ----------------------------------------------------------------------------
module roi_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  roi_pkg::slab_item_t  item_i,
  input  logic                 pop_i,
  output roi_pkg::slab_item_t  item_o,
  output roi_pkg::queue_stat_t stat_o
);

  roi_pkg::slab_item_t mem_q [roi_pkg::Q_DEPTH];
  logic [roi_pkg::Q_PTR_W-1:0] wr_q, rd_q;
  logic [roi_pkg::Q_CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == roi_pkg::Q_CNT_W'(roi_pkg::Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + roi_pkg::Q_PTR_W'(1);
      if (do_pop)  rd_q <= rd_q + roi_pkg::Q_PTR_W'(1);
      cnt_q <= cnt_q + roi_pkg::Q_CNT_W'(do_push) - roi_pkg::Q_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

FILE: rtl/roi_div.sv
// ----------------------------------------------------------------------------
// Ray/OBB slab divider
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module roi_div (
  input  logic                        clk_i,
  input  logic [roi_pkg::NMAG_W-1:0]  num_i,
  input  logic [roi_pkg::FMAG_W-1:0]  den_i,
  output logic [roi_pkg::QB-1:0]      quo_o
);

  localparam int DW = roi_pkg::FMAG_W;

  logic [roi_pkg::N_W-1:0] num_sh;
  logic [DW-1:0]           rem_q [roi_pkg::QB+1];
  logic [DW-1:0]           den_q [roi_pkg::QB+1];
  logic [roi_pkg::QB-1:0]  w_q   [roi_pkg::QB+1];
  logic [DW-1:0]           rem_d [roi_pkg::QB];
  logic [roi_pkg::QB-1:0]  w_d   [roi_pkg::QB];

  assign num_sh = {num_i, {roi_pkg::T_SH{1'b0}}};

  // Each stage: shift in the next numerator bit, subtract when it fits.
  always_comb begin
    logic [DW:0] trial;
    logic        ge;
    for (int s = 0; s < roi_pkg::QB; s++) begin
      trial    = {rem_q[s], w_q[s][roi_pkg::QB-1]};
      ge       = (trial >= {1'b0, den_q[s]});
      rem_d[s] = ge ? DW'(trial - {1'b0, den_q[s]}) : DW'(trial);
      w_d[s]   = {w_q[s][roi_pkg::QB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= DW'(num_sh >> roi_pkg::QB);
    w_q[0]   <= num_sh[roi_pkg::QB-1:0];
    den_q[0] <= den_i;
    for (int s = 0; s < roi_pkg::QB; s++) begin
      rem_q[s+1] <= rem_d[s];
      w_q[s+1]   <= w_d[s];
      den_q[s+1] <= den_q[s];
    end
  end

  assign quo_o = w_q[roi_pkg::QB];

endmodule

FILE: rtl/roi_back.sv
// ----------------------------------------------------------------------------
// Ray/OBB back end
// Divides out the slab distances, bounds the interval, forms the result.
// ----------------------------------------------------------------------------
module roi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  roi_pkg::slab_item_t item_i,
  output logic                res_valid_o,
  output roi_pkg::result_t    res_o
);

  localparam int QB = roi_pkg::QB;
  localparam int TW = roi_pkg::T_W;

  logic [QB-1:0] quo_a [roi_pkg::AXES];
  logic [QB-1:0] quo_b [roi_pkg::AXES];

  for (genvar g = 0; g < roi_pkg::AXES; g++) begin : g_div
    roi_div u_div_a (.clk_i, .num_i(item_i.na[g]), .den_i(item_i.fmag[g]), .quo_o(quo_a[g]));
    roi_div u_div_b (.clk_i, .num_i(item_i.nb[g]), .den_i(item_i.fmag[g]), .quo_o(quo_b[g]));
  end

  logic            vq [QB+1];
  roi_pkg::side_t  side_q [QB+1];
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QB; s++) vq[s] <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      vq[0] <= item_valid_i;
      for (int s = 0; s < QB; s++) vq[s+1] <= vq[s];
      v1_q <= vq[QB];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{ray: item_i.ray, par: item_i.par, pmiss: item_i.pmiss,
                   neg_a: item_i.neg_a, neg_b: item_i.neg_b};
    for (int s = 0; s < QB; s++) side_q[s+1] <= side_q[s];
  end

  // Stage 1: signed slab parameters.
  logic signed [TW-1:0] tv1_d [roi_pkg::FACES];
  logic signed [TW-1:0] tv1_q [roi_pkg::FACES];
  roi_pkg::side_t side1_q;

  always_comb begin
    for (int i = 0; i < roi_pkg::AXES; i++) begin
      tv1_d[2*i]   = side_q[QB].neg_a[i] ? -$signed({2'b00, quo_a[i]})
                                         :  $signed({2'b00, quo_a[i]});
      tv1_d[2*i+1] = side_q[QB].neg_b[i] ? -$signed({2'b00, quo_b[i]})
                                         :  $signed({2'b00, quo_b[i]});
    end
  end

  // Stage 2: per slab entry and exit.
  logic signed [TW-1:0] mn_d [roi_pkg::AXES], mx_d [roi_pkg::AXES];
  logic signed [TW-1:0] mn2_q [roi_pkg::AXES], mx2_q [roi_pkg::AXES];
  logic signed [TW-1:0] tv2_q [roi_pkg::FACES];
  logic [roi_pkg::FACES-1:0] tvld_d, tvld2_q;
  logic [roi_pkg::AXES-1:0]  pmiss2_q;
  roi_pkg::ray_t ray2_q;

  always_comb begin
    for (int i = 0; i < roi_pkg::AXES; i++) begin
      tvld_d[2*i]   = !side1_q.par[i];
      tvld_d[2*i+1] = !side1_q.par[i];
      if (side1_q.par[i]) begin
        mn_d[i] = roi_pkg::T_NUNB;
        mx_d[i] = roi_pkg::T_UNB;
      end else if (tv1_q[2*i] < tv1_q[2*i+1]) begin
        mn_d[i] = tv1_q[2*i];
        mx_d[i] = tv1_q[2*i+1];
      end else begin
        mn_d[i] = tv1_q[2*i+1];
        mx_d[i] = tv1_q[2*i];
      end
    end
  end

  // Stage 3: interval bounds.
  logic signed [TW-1:0] lo_d, hi_d, lo3_q, hi3_q;
  logic signed [TW-1:0] tv3_q [roi_pkg::FACES];
  logic [roi_pkg::FACES-1:0] tvld3_q;
  logic anym3_q;
  roi_pkg::ray_t ray3_q;

  always_comb begin
    lo_d = roi_pkg::T_NUNB;
    hi_d = roi_pkg::T_UNB;
    for (int i = 0; i < roi_pkg::AXES; i++) begin
      if (mn2_q[i] > lo_d) lo_d = mn2_q[i];
      if (mx2_q[i] < hi_d) hi_d = mx2_q[i];
    end
  end

  // Stage 4: verdict, chosen parameter and its saturated form.
  logic signed [TW-1:0] tr_d, tr4_q;
  logic signed [roi_pkg::TS_W-1:0] ts_d, ts4_q;
  logic signed [TW-1:0] tv4_q [roi_pkg::FACES];
  logic [roi_pkg::FACES-1:0] tvld4_q;
  logic miss_d, miss4_q;
  roi_pkg::ray_t ray4_q;

  always_comb begin
    miss_d = anym3_q || hi3_q[TW-1] || (lo3_q > hi3_q);
    tr_d   = lo3_q[TW-1] ? hi3_q : lo3_q;
    if (tr_d > roi_pkg::T_SMAX) begin
      ts_d = roi_pkg::TS_W'(roi_pkg::T_SMAX);
    end else if (tr_d < roi_pkg::T_SMIN) begin
      ts_d = roi_pkg::TS_W'(roi_pkg::T_SMIN);
    end else begin
      ts_d = roi_pkg::TS_W'(tr_d);
    end
  end

  // Stage 5: face match and direction times t.
  logic signed [roi_pkg::DT_W-1:0] dt_d [roi_pkg::AXES], dt5_q [roi_pkg::AXES];
  logic signed [roi_pkg::COMP_W-1:0] dir4 [roi_pkg::AXES];
  roi_pkg::face_e face_d, face5_q;
  logic signed [roi_pkg::TS_W-1:0] ts5_q;
  logic miss5_q;
  roi_pkg::ray_t ray5_q;

  always_comb begin
    logic signed [TW:0] diff;
    dir4[0] = ray4_q.dir_x;
    dir4[1] = ray4_q.dir_y;
    dir4[2] = ray4_q.dir_z;
    for (int k = 0; k < roi_pkg::AXES; k++) dt_d[k] = dir4[k] * ts4_q;
    face_d = roi_pkg::FACE_NONE;
    for (int i = 0; i < roi_pkg::FACES; i++) begin
      diff = (TW+1)'(tr4_q) - (TW+1)'(tv4_q[i]);
      if (tvld4_q[i] && (diff <= (TW+1)'(roi_pkg::T_TOL))
          && (diff >= -(TW+1)'(roi_pkg::T_TOL))) begin
        face_d = roi_pkg::FACE_LUT[i];
      end
    end
  end

  // Stage 6: hit point, saturation, miss word.
  logic signed [roi_pkg::COMP_W-1:0] org5 [roi_pkg::AXES];
  logic signed [roi_pkg::COMP_W-1:0] pt_d [roi_pkg::AXES];
  roi_pkg::result_t res_d, res_q;

  always_comb begin
    logic signed [roi_pkg::PS_W-1:0] ps;
    org5[0] = ray5_q.origin_x;
    org5[1] = ray5_q.origin_y;
    org5[2] = ray5_q.origin_z;
    for (int k = 0; k < roi_pkg::AXES; k++) begin
      ps = roi_pkg::PS_W'(org5[k]) + roi_pkg::PS_W'(dt5_q[k] >>> roi_pkg::T_SH);
      if (ps > roi_pkg::P_MAX)      ps = roi_pkg::P_MAX;
      else if (ps < roi_pkg::P_MIN) ps = roi_pkg::P_MIN;
      pt_d[k] = roi_pkg::COMP_W'(ps);
    end
    if (miss5_q) begin
      res_d.hit     = 1'b0;
      res_d.t_hit   = roi_pkg::MISS_T;
      res_d.point_x = '0;
      res_d.point_y = '0;
      res_d.point_z = '0;
      res_d.face    = roi_pkg::FACE_NONE;
    end else begin
      res_d.hit     = 1'b1;
      res_d.t_hit   = ts5_q;
      res_d.point_x = pt_d[0];
      res_d.point_y = pt_d[1];
      res_d.point_z = pt_d[2];
      res_d.face    = face5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tv1_q    <= tv1_d;
    side1_q  <= side_q[QB];
    mn2_q    <= mn_d;
    mx2_q    <= mx_d;
    tv2_q    <= tv1_q;
    tvld2_q  <= tvld_d;
    pmiss2_q <= side1_q.pmiss;
    ray2_q   <= side1_q.ray;
    lo3_q    <= lo_d;
    hi3_q    <= hi_d;
    tv3_q    <= tv2_q;
    tvld3_q  <= tvld2_q;
    anym3_q  <= |pmiss2_q;
    ray3_q   <= ray2_q;
    tr4_q    <= tr_d;
    ts4_q    <= ts_d;
    tv4_q    <= tv3_q;
    tvld4_q  <= tvld3_q;
    miss4_q  <= miss_d;
    ray4_q   <= ray3_q;
    dt5_q    <= dt_d;
    face5_q  <= face_d;
    ts5_q    <= ts4_q;
    miss5_q  <= miss4_q;
    ray5_q   <= ray4_q;
    res_q    <= res_d;
  end

  assign res_valid_o = v6_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/ray_obb_intersect_unit.sv
// ----------------------------------------------------------------------------
// Ray/OBB intersect unit
// Slab test of a stream of rays against one configured oriented box.
// ----------------------------------------------------------------------------
// Usage:
//   Write the box through cfg_we_i / cfg_idx_i / cfg_wdata_i while no ray is
//   in flight: index 0 centre, 1..3 the axes, 4 the half sizes. Any other
//   index is dropped. Writes take effect at the clock edge.
//   Present a ray word on ray_i with start_i high; it is taken at an edge
//   where busy_o is low. A new ray may follow every cycle.
//   Each result word appears on res_o for exactly one cycle with res_valid_o
//   high. The receiver cannot hold results off, so the back end never stalls
//   and busy_o stays low in normal use.
//   A ray passes through the front end, the queue, the slab dividers
//   (QB = 44 quotient bits at the default tolerance) and the combine stages
//   before its result shows. Throughput is one ray per cycle while busy_o
//   is low, set by the bit-per-stage divider pipeline.
//   Reset clears all control state and loads the box registers with unit axes,
//   a zero centre and zero half sizes; stale payload in the pipeline is never flagged valid.
// ----------------------------------------------------------------------------
`include "ray_obb_intersect_unit_assert.svh"

module ray_obb_intersect_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  roi_pkg::ray_t                     ray_i,
  output logic                              res_valid_o,
  output roi_pkg::result_t                  res_o,
  input  logic                              cfg_we_i,
  input  logic [roi_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [roi_pkg::REG_W-1:0]         cfg_wdata_i
);

  roi_pkg::cfg_t        cfg_q;
  roi_pkg::slab_item_t  front_item, queue_item;
  roi_pkg::queue_stat_t q_stat;
  logic                 front_push, accept, q_pop;

  // Box registers: hold until rewritten, drop unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center  <= roi_pkg::RST_CENTER;
      cfg_q.axis[0] <= roi_pkg::RST_AXIS1;
      cfg_q.axis[1] <= roi_pkg::RST_AXIS2;
      cfg_q.axis[2] <= roi_pkg::RST_AXIS3;
      cfg_q.half    <= roi_pkg::RST_HALF;
    end else if (cfg_we_i) begin
      unique case (roi_pkg::reg_idx_e'(cfg_idx_i))
        roi_pkg::REG_CENTER: cfg_q.center  <= cfg_wdata_i;
        roi_pkg::REG_AXIS1:  cfg_q.axis[0] <= cfg_wdata_i;
        roi_pkg::REG_AXIS2:  cfg_q.axis[1] <= cfg_wdata_i;
        roi_pkg::REG_AXIS3:  cfg_q.axis[2] <= cfg_wdata_i;
        roi_pkg::REG_HALF:   cfg_q.half    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Take a ray only while the queue has room for it.
  assign busy_o = q_stat.full;
  assign accept = start_i && !busy_o;

  roi_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i (accept),
    .ray_i,
    .push_o     (front_push),
    .item_o     (front_item)
  );

  // The back end drains the queue every cycle it holds a word.
  assign q_pop = !q_stat.empty;

  roi_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (front_push),
    .item_i (front_item),
    .pop_i  (q_pop),
    .item_o (queue_item),
    .stat_o (q_stat)
  );

  roi_back u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (q_pop),
    .item_i       (queue_item),
    .res_valid_o,
    .res_o
  );

  // A classified ray is never dropped at the queue.
  `ROI_ASSERT_HOLDS(a_push_room, front_push, !q_stat.full)
  // A pushed word is still waiting or being drained the next cycle.
  `ROI_ASSERT_NEXT(a_push_lands, front_push, !q_stat.empty)
  // A miss carries the fixed miss word.
  `ROI_ASSERT_HOLDS(a_miss_word, res_valid_o && !res_o.hit,
                    (res_o.t_hit == roi_pkg::MISS_T) && (res_o.face == roi_pkg::FACE_NONE))
  // A hit never lies behind the origin.
  `ROI_ASSERT_HOLDS(a_hit_ahead, res_valid_o && res_o.hit, !res_o.t_hit[roi_pkg::TS_W-1])

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Ray/OBB intersect unit testbench
// Streams rays against a series of configured boxes and checks each result
// word against a local slab-method predictor, field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import roi_pkg::*;

  // Cycles with no ray taken and no result word before the run is abandoned:
  // the pipeline is short and idles are short, so this is generous.
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 70;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  ray_t                ray_i = '0;
  logic                res_valid_o;
  result_t             res_o;
  logic                cfg_we_i = 1'b0;
  logic [IDX_W-1:0]    cfg_idx_i = '0;
  logic [REG_W-1:0]    cfg_wdata_i = '0;

  // Local copy of the box registers, updated as each write goes out.
  logic [REG_W-1:0]    box_reg [5];
  result_t             hits_due [$];
  int unsigned         fail_count = 0;
  int unsigned         quiet_cycles = 0;
  bit                  calm = 1'b0;  // set for a stretch with no idling

  ray_obb_intersect_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .ray_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // Slab-method trace of one ray against the box held in box_reg.
  function automatic result_t trace_ray(ray_t r);
    longint org [3];
    longint dr [3];
    longint off [3];
    longint tv [6];
    bit     tok [6];
    longint lo, hi, f, e, s, a, ta, tb, mn, mx, tr, ts, pt, pmax, pmin;
    bit     miss;
    result_t res;
    begin
      org[0] = sx16(r.origin_x); org[1] = sx16(r.origin_y); org[2] = sx16(r.origin_z);
      dr[0] = sx16(r.dir_x); dr[1] = sx16(r.dir_y); dr[2] = sx16(r.dir_z);
      for (int k = 0; k < 3; k++)
        off[k] = sx16(box_reg[REG_CENTER][16*k +: 16]) - org[k];
      for (int i = 0; i < 6; i++) begin
        tv[i] = 0;
        tok[i] = 1'b0;
      end
      lo = -(64'sd1 <<< 62);
      hi = 64'sd1 <<< 62;
      miss = 1'b0;
      for (int i = 0; i < NUM_AXES && i < 3; i++) begin
        f = 0;
        e = 0;
        for (int k = 0; k < 3; k++) begin
          a = sx16(box_reg[1+i][16*k +: 16]);
          f += a * dr[k];
          e += a * off[k];
        end
        s = longint'(box_reg[REG_HALF][16*i +: 16]) <<< 14;
        if ((f < 0 ? -f : f) <= longint'(ZERO_TOLERANCE) * 16384) begin
          // Parallel slab: outside misses, inside sets no limit.
          if (e > s || e < -s) begin
            miss = 1'b1;
            break;
          end
          continue;
        end
        ta = ((e + s) * 4194304) / f;
        tb = ((e - s) * 4194304) / f;
        tv[2*i] = ta;
        tv[2*i+1] = tb;
        tok[2*i] = 1'b1;
        tok[2*i+1] = 1'b1;
        mn = ta < tb ? ta : tb;
        mx = ta < tb ? tb : ta;
        if (mn > lo) lo = mn;
        if (mx < hi) hi = mx;
      end
      if (!miss && (hi < 0 || lo > hi)) miss = 1'b1;
      res = '0;
      if (miss) begin
        res.t_hit = MISS_T;
        res.face = FACE_NONE;
        return res;
      end
      tr = lo < 0 ? hi : lo;
      ts = tr < -64'sd2147483648 ? -64'sd2147483648 :
           (tr > 64'sd2147483647 ? 64'sd2147483647 : tr);
      pmax = (64'sd1 <<< (PT_W - 1)) - 1;
      pmin = -pmax - 1;
      res.hit = 1'b1;
      res.t_hit = ts[31:0];
      for (int k = 0; k < 3; k++) begin
        pt = org[k] + ((dr[k] * ts) >>> 22);
        pt = pt < pmin ? pmin : (pt > pmax ? pmax : pt);
        case (k)
          0: res.point_x = pt[15:0];
          1: res.point_y = pt[15:0];
          default: res.point_z = pt[15:0];
        endcase
      end
      res.face = FACE_NONE;
      // Last face within tolerance of the chosen t wins.
      for (int i = 0; i < 6; i++)
        if (tok[i] && ((tr - tv[i]) < 0 ? tv[i] - tr : tr - tv[i]) <= ZERO_TOLERANCE)
          res.face = 3'(i);
      return res;
    end
  endfunction

  // Record each accepted ray and check each result word as it goes past.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o || (start_i && !busy_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (res_valid_o) begin
        if (hits_due.size() == 0) begin
          $error("result word with nothing outstanding");
          fail_count++;
        end else begin
          result_t want;
          want = hits_due.pop_front();
          if (res_o.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, res_o.hit);
            fail_count++;
          end
          if (res_o.t_hit !== want.t_hit) begin
            $error("t_hit: expected %0d, got %0d", want.t_hit, res_o.t_hit);
            fail_count++;
          end
          if (res_o.point_x !== want.point_x) begin
            $error("point_x: expected %0d, got %0d", want.point_x, res_o.point_x);
            fail_count++;
          end
          if (res_o.point_y !== want.point_y) begin
            $error("point_y: expected %0d, got %0d", want.point_y, res_o.point_y);
            fail_count++;
          end
          if (res_o.point_z !== want.point_z) begin
            $error("point_z: expected %0d, got %0d", want.point_z, res_o.point_z);
            fail_count++;
          end
          if (res_o.face !== want.face) begin
            $error("face: expected %0d, got %0d", want.face, res_o.face);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        hits_due.insert(hits_due.size(), trace_ray(ray_i));
      end
    end
  end

  // Watchdog: abandon the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Present one ray word and hold it until the unit takes it. Called and
  // returns at a rising edge; start stays high so back-to-back words flow.
  task automatic send_ray(ray_t r);
    bit was_busy;
    if (!calm && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    ray_i <= r;
    start_i <= 1'b1;
    forever begin
      @(negedge clk_i);
      was_busy = busy_o;
      @(posedge clk_i);
      if (!was_busy) break;
    end
  endtask

  // Drop start, let every outstanding result arrive, then idle a little.
  task automatic drain;
    start_i <= 1'b0;
    @(negedge clk_i);
    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [REG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    box_reg[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic load_box(logic [REG_W-1:0] c, logic [REG_W-1:0] a1, logic [REG_W-1:0] a2,
                          logic [REG_W-1:0] a3, logic [REG_W-1:0] h);
    drain();
    write_reg(REG_CENTER, c);
    write_reg(REG_AXIS1, a1);
    write_reg(REG_AXIS2, a2);
    write_reg(REG_AXIS3, a3);
    write_reg(REG_HALF, h);
    cfg_we_i <= 1'b0;
  endtask

  function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.origin_x = 16'(ox); r.origin_y = 16'(oy); r.origin_z = 16'(oz);
    r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
    return r;
  endfunction

  function automatic int rand_dir_comp;
    return int'($urandom_range(32768)) - 16384;
  endfunction

  // Mostly rays near the box with plausible directions; the rest is noise.
  function automatic ray_t rand_ray;
    ray_t r;
    int   spread, pick;
    pick = $urandom_range(99);
    spread = ($urandom_range(3) == 0) ? 16384 : 2048;
    r.origin_x = 16'(sx16(box_reg[REG_CENTER][15:0]) + $urandom_range(2*spread) - spread);
    r.origin_y = 16'(sx16(box_reg[REG_CENTER][31:16]) + $urandom_range(2*spread) - spread);
    r.origin_z = 16'(sx16(box_reg[REG_CENTER][47:32]) + $urandom_range(2*spread) - spread);
    r.dir_x = 16'(rand_dir_comp());
    r.dir_y = 16'(rand_dir_comp());
    r.dir_z = 16'(rand_dir_comp());
    if (pick < 15) begin
      // Axis-aligned direction: two parallel slabs for an axis-aligned box.
      r.dir_x = 0; r.dir_y = 0; r.dir_z = 0;
      case ($urandom_range(2))
        0: r.dir_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        1: r.dir_y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        default: r.dir_z = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      endcase
    end else if (pick < 22) begin
      // Near-zero components around the parallel tolerance.
      r.dir_x = 16'(int'($urandom_range(4)) - 2);
      r.dir_y = 16'(int'($urandom_range(4)) - 2);
    end else if (pick < 35) begin
      r.origin_x = 16'($urandom);
      r.origin_y = 16'($urandom);
      r.origin_z = 16'($urandom);
    end
    return r;
  endfunction

  task automatic test_reset_box;
    // Default registers: unit axes, zero half size, centre at the origin.
    box_reg[REG_CENTER] = RST_CENTER;
    box_reg[REG_AXIS1] = RST_AXIS1;
    box_reg[REG_AXIS2] = RST_AXIS2;
    box_reg[REG_AXIS3] = RST_AXIS3;
    box_reg[REG_HALF] = RST_HALF;
    send_ray(mk_ray(0, 0, 0, 0, 0, 0));
    send_ray(mk_ray(-256, 0, 0, 16384, 0, 0));
    send_ray(mk_ray(256, 256, 0, 16384, 0, 0));
  endtask

  task automatic test_directed;
    load_box(48'h0000_0000_0000, RST_AXIS1, RST_AXIS2, RST_AXIS3, 48'h0200_0200_0200);
    send_ray(mk_ray(0, 0, 0, 0, 0, 0));                 // inside, no limit at all
    send_ray(mk_ray(2048, 0, 0, 0, 0, 0));              // outside, all parallel
    send_ray(mk_ray(-2560, 0, 0, 16384, 0, 0));         // head-on, enters -axis1 face
    send_ray(mk_ray(2560, 0, 0, 16384, 0, 0));          // box behind the ray
    send_ray(mk_ray(0, 0, 0, 0, -16384, 0));            // origin inside, t is tmax
    send_ray(mk_ray(-2560, 2560, 0, 11585, -11585, 0)); // corner, face tie
    send_ray(mk_ray(-2560, 1536, 0, 16384, 1, 0));      // within parallel tolerance
    send_ray(mk_ray(-2560, 1536, 0, 16384, 2, 0));      // just past the tolerance
    send_ray(mk_ray(-2560, 2048, 0, 16384, 16384, 0));  // slabs disjoint in t
    send_ray(mk_ray(-32768, -32768, -32768, 16384, 16384, 16384));
    send_ray(mk_ray(32767, 32767, 32767, -16384, -16384, -16384));
    send_ray(mk_ray(-32768, 0, 0, 16384, 0, 0));
    send_ray(mk_ray(32767, 0, 0, -16384, 0, 0));
    // Huge box, far centre: t saturates and the point clamps.
    load_box(48'h8000_7FFF_8000, RST_AXIS1, RST_AXIS2, RST_AXIS3, 48'hFFFF_FFFF_FFFF);
    send_ray(mk_ray(0, 0, 0, 1, 2, 3));
    send_ray(mk_ray(32767, -32768, 32767, -16384, 16384, -16384));
    send_ray(mk_ray(0, 0, 0, 16384, 0, 0));
    send_ray(mk_ray(-32768, 32767, -32768, 16384, -16384, 16384));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_ray(rand_ray());
  endtask

  task automatic test_random;
    logic [REG_W-1:0] half;
    // Axis-aligned boxes of modest size.
    for (int p = 0; p < 3; p++) begin
      half = {16'($urandom_range(4096, 64)), 16'($urandom_range(4096, 64)),
              16'($urandom_range(4096, 64))};
      load_box({16'($urandom_range(4096)), 16'($urandom_range(4096)),
                16'($urandom_range(4096))}, RST_AXIS1, RST_AXIS2, RST_AXIS3, half);
      calm = (p == 1);
      random_phase(200);
      calm = 1'b0;
    end
    // Rotated by 45 degrees about z.
    load_box(48'h0100_FF00_0080, {16'd0, 16'd11585, 16'd11585},
             {16'd0, 16'd11585, -16'sd11585}, RST_AXIS3, 48'h0300_0180_0800);
    random_phase(200);
    // Extreme axis components, not unit length.
    load_box(48'h0000_0000_0000, {16'h7FFF, 16'h8000, 16'h7FFF},
             {16'h8000, 16'h7FFF, 16'h0001}, {16'h0001, 16'hFFFF, 16'h8000},
             48'h0800_0800_0800);
    random_phase(200);
    // Zero half size: a point box.
    load_box(48'h0000_0000_0000, RST_AXIS1, RST_AXIS2, RST_AXIS3, 48'h0);
    random_phase(100);
    // Fully random registers.
    for (int p = 0; p < 3; p++) begin
      load_box({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
               {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
               {16'($urandom), 32'($urandom)});
      random_phase(200);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_box();
    test_directed();
    test_random();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && hits_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

FILE: ray_obb_intersect_unit.f
+incdir+rtl
rtl/roi_pkg.sv
rtl/roi_front.sv
rtl/roi_queue.sv
rtl/roi_div.sv
rtl/roi_back.sv
rtl/ray_obb_intersect_unit.sv
dv/tb.sv
